FILE: hdl/rcgu_pkg.sv
// ----------------------------------------------------------------------------
// rcgu_pkg
// Shared constants and types for the range greater-than counter.
// ----------------------------------------------------------------------------
package rcgu_pkg;

  // Table size and largest value kept in the table.
  localparam int DEPTH     = 1024;
  localparam int VALUE_MAX = 16383;

  // Port field widths.
  localparam int IDX_W   = 11;
  localparam int VAL_W   = 14;
  localparam int COUNT_W = 11;

  // Memory address width and a width that holds both an index and DEPTH.
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W     = (ADDR_W + 1 > IDX_W) ? ADDR_W + 1 : IDX_W;
  localparam int VMAX_W    = (VAL_W > 16) ? VAL_W + 1 : 17;

  // Item opcodes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Write port of the value store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } ram_wr_t;

endpackage

FILE: hdl/rcgu_ram.sv
// ----------------------------------------------------------------------------
// rcgu_ram
// Value store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rcgu_ram (
  input  logic                          clk,
  input  rcgu_pkg::ram_wr_t             wr,
  input  logic [rcgu_pkg::ADDR_W-1:0]   rd_addr,
  output logic [rcgu_pkg::VAL_W-1:0]    rd_data
);

  logic [rcgu_pkg::VAL_W-1:0] mem [rcgu_pkg::DEPTH];
  logic [rcgu_pkg::VAL_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/range_count_greater_with_updates.sv
// ----------------------------------------------------------------------------
// range_count_greater_with_updates
// Value table with point writes and range "greater than" count queries.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                                        | Direction
//  --------+----------------------------------------------+----------
//  in      | in_valid/in_ready, op, index, index_end, value | into block
//  out     | out_valid/out_ready, count                   | out of block
//
// After reset the block sweeps the store to zero, one entry a cycle, with
// in_ready low. A write item is written to the store at acceptance.
// A query over n entries (after clipping to 1..DEPTH) passes through SCAN,
// one store read per cycle through the single read port, then DRAIN for the
// registered read data, then DONE, which loads the result register. An empty
// range goes straight to DONE. A query waits in its last state while the
// result register is still full; in_ready stays high while a finished result
// waits.
//
module range_count_greater_with_updates (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [rcgu_pkg::IDX_W-1:0]     in_index,
  input  logic [rcgu_pkg::IDX_W-1:0]     in_index_end,
  input  logic [rcgu_pkg::VAL_W-1:0]     in_value,

  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [rcgu_pkg::COUNT_W-1:0]   out_count
);

  localparam int ADDR_W  = rcgu_pkg::ADDR_W;
  localparam int CMP_W   = rcgu_pkg::CMP_W;
  localparam int VAL_W   = rcgu_pkg::VAL_W;
  localparam int COUNT_W = rcgu_pkg::COUNT_W;
  localparam int VMAX_W  = rcgu_pkg::VMAX_W;

  localparam logic [CMP_W-1:0]  DEPTH_C    = CMP_W'(rcgu_pkg::DEPTH);
  localparam logic [CMP_W-1:0]  ONE_C      = CMP_W'(1);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(rcgu_pkg::DEPTH - 1);
  localparam logic [VMAX_W-1:0] VMAX_C     = VMAX_W'(rcgu_pkg::VALUE_MAX);
  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  rcgu_pkg::state_t state_r, state_nxt;

  logic [ADDR_W-1:0]  addr_r, addr_nxt;        // scan or clear pointer
  logic [ADDR_W-1:0]  last_r, last_nxt;        // last address of the scan
  logic [VAL_W-1:0]   thresh_r, thresh_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               rd_pend_r, rd_pend_nxt;  // store read data is for a scan entry
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  rcgu_pkg::ram_wr_t           ram_wr;
  logic [ADDR_W-1:0]           ram_rd_addr;
  logic [VAL_W-1:0]            ram_rd_data;

  logic               in_acc;
  logic               out_free;
  logic [CMP_W-1:0]   idx_w, idx_end_w, lo_w, hi_w;
  logic               wr_in_range;
  logic               q_empty;
  logic [VAL_W-1:0]   wr_val;

  rcgu_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready  = (state_r == rcgu_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  // Clip the query range to the table and check write addresses.
  always_comb begin
    idx_w       = CMP_W'(in_index);
    idx_end_w   = CMP_W'(in_index_end);
    lo_w        = (idx_w < ONE_C) ? ONE_C : idx_w;
    hi_w        = (idx_end_w > DEPTH_C) ? DEPTH_C : idx_end_w;
    q_empty     = (lo_w > hi_w);
    wr_in_range = (idx_w >= ONE_C) && (idx_w <= DEPTH_C);
  end

  // Clamp write values into 1..VALUE_MAX.
  always_comb begin
    if (in_value == '0) begin
      wr_val = VAL_W'(1);
    end else if (VMAX_W'(in_value) > VMAX_C) begin
      wr_val = VAL_W'(rcgu_pkg::VALUE_MAX);
    end else begin
      wr_val = in_value;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rcgu_pkg::ST_CLEAR: begin
        if (addr_r == LAST_ADDR) begin
          state_nxt = rcgu_pkg::ST_IDLE;
        end
      end
      rcgu_pkg::ST_IDLE: begin
        if (in_acc && in_op == rcgu_pkg::OP_QUERY) begin
          state_nxt = q_empty ? rcgu_pkg::ST_DONE : rcgu_pkg::ST_SCAN;
        end
      end
      rcgu_pkg::ST_SCAN: begin
        if (addr_r == last_r) begin
          state_nxt = rcgu_pkg::ST_DRAIN;
        end
      end
      rcgu_pkg::ST_DRAIN: begin
        state_nxt = rcgu_pkg::ST_DONE;
      end
      rcgu_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rcgu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcgu_pkg::ST_CLEAR;
      end
    endcase
  end

  // Datapath and store control.
  always_comb begin
    addr_nxt      = addr_r;
    last_nxt      = last_r;
    thresh_nxt    = thresh_r;
    cnt_nxt       = cnt_r;
    rd_pend_nxt   = 1'b0;
    ram_wr.en     = 1'b0;
    ram_wr.addr   = addr_r;
    ram_wr.data   = '0;
    ram_rd_addr   = addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;

    // Count the entry read in the previous cycle.
    if (rd_pend_r && (ram_rd_data > thresh_r) && (cnt_r != COUNT_SAT)) begin
      cnt_nxt = cnt_r + COUNT_W'(1);
    end

    case (state_r)
      rcgu_pkg::ST_CLEAR: begin
        ram_wr.en = 1'b1;
        addr_nxt  = addr_r + ADDR_W'(1);
      end
      rcgu_pkg::ST_IDLE: begin
        if (in_acc && in_op == rcgu_pkg::OP_WRITE) begin
          ram_wr.en   = wr_in_range;
          ram_wr.addr = ADDR_W'(idx_w - ONE_C);
          ram_wr.data = wr_val;
        end
        if (in_acc && in_op == rcgu_pkg::OP_QUERY) begin
          addr_nxt   = ADDR_W'(lo_w - ONE_C);
          last_nxt   = ADDR_W'(hi_w - ONE_C);
          thresh_nxt = in_value;
          cnt_nxt    = '0;
        end
      end
      rcgu_pkg::ST_SCAN: begin
        // Issue one read per cycle and advance.
        rd_pend_nxt = 1'b1;
        addr_nxt    = addr_r + ADDR_W'(1);
      end
      rcgu_pkg::ST_DRAIN: begin
      end
      rcgu_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcgu_pkg::ST_CLEAR;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    thresh_r    <= thresh_nxt;
    cnt_r       <= cnt_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule
